// ===== hw/rtl/htsd_pkg.sv =====
package htsd_pkg;

  // Field and state widths
  localparam int unsigned PicW      = 16;
  localparam int unsigned CtbLog2W  = 3;
  localparam int unsigned TileIdxW  = 5;
  localparam int unsigned ExplW     = 13;
  localparam int unsigned CtbsW     = 14;
  localparam int unsigned SumW      = 18;
  localparam int unsigned LumaW     = 20;
  localparam int unsigned CfgIdxW   = 3;

  // Serial divider sizing: (index + 1) * N stays below 2^18 when the
  // divider is used, and the divisor is a tile count of at most 32.
  localparam int unsigned DivDividendW = 18;
  localparam int unsigned DivDivisorW  = 6;

  // Tile count limit and legal CTB size range
  localparam int unsigned MaxTiles = 32;
  localparam logic [CtbLog2W-1:0] CtbLog2Min = 3'd3;
  localparam logic [CtbLog2W-1:0] CtbLog2Max = 3'd6;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPicSizeLuma     = 3'd0,
    CfgCtbLog2Size     = 3'd1,
    CfgTileCountMinus1 = 3'd2,
    CfgUniformSpacing  = 3'd3,
    CfgMinTileSize     = 3'd4
  } cfg_idx_e;

endpackage

// ===== hw/rtl/htsd_div.sv =====
module htsd_div #(
  parameter int unsigned DividendW = 18,
  parameter int unsigned DivisorW  = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int unsigned CntW = (DividendW > 1) ? $clog2(DividendW) : 1;

  logic [DividendW-1:0] shift_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  rem_d;
  logic [DivisorW-1:0]  divisor_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DivisorW:0]    trial;
  logic                 qbit;

  // One restoring step: bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, shift_q[DividendW-1]};
  assign qbit  = (trial >= {1'b0, divisor_q});
  assign rem_d = qbit ? DivisorW'(trial - {1'b0, divisor_q}) : trial[DivisorW-1:0];

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q   <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      shift_q <= {shift_q[DividendW-2:0], qbit};
      rem_q   <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

endmodule

// ===== hw/rtl/hevc_tile_size_derivation.sv =====
// Tile size derivation along one picture dimension (columns or rows).
// Configuration goes through the always-ready cfg channel (index and data);
// write it only while no tile is in progress; the block does not enforce it.
// Each beat on the s_axis channel asks for the next tile; in explicit mode it
// carries that tile's size in CTBs minus one, otherwise its data is ignored.
// Each input beat yields exactly one m_axis beat: the tile size in luma
// samples, its index, the below-minimum and negative-remainder flags, and
// tlast marking the final tile of the dimension.
// Explicit tiles and the last uniform tile go from acceptance to StFinish and
// then to the output register; other uniform tiles first wait in StDivide on
// the bit-serial divider, which resolves one quotient bit per cycle over an
// 18-bit dividend. A new beat is taken in the cycle after the result loads.
// The result sits in an output register, so the next beat is accepted while
// it waits; if the receiver stalls, the block holds the following result
// until the output register frees up.
// Reset returns the configuration to its defaults (1920 samples, 64-sample
// CTBs, one tile, uniform spacing, minimum 256) and the tile position to zero.
module hevc_tile_size_derivation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] explicit_size_minus1
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [19:0] tile_size_luma, [24:20] tile_index,
                                      // [25] below_minimum, [26] remainder_negative
  output logic        m_axis_tlast    // last_tile
);

  localparam int unsigned CtbsW    = htsd_pkg::CtbsW;
  localparam int unsigned SumW     = htsd_pkg::SumW;
  localparam int unsigned LumaW    = htsd_pkg::LumaW;
  localparam int unsigned TileIdxW = htsd_pkg::TileIdxW;
  localparam int unsigned CtbLog2W = htsd_pkg::CtbLog2W;
  localparam int unsigned PicW     = htsd_pkg::PicW;
  localparam int unsigned ExplW    = htsd_pkg::ExplW;
  localparam int unsigned DivNW    = htsd_pkg::DivDividendW;
  localparam int unsigned DivDW    = htsd_pkg::DivDivisorW;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StFinish
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [PicW-1:0]     cfg_pic_q;
  logic [CtbLog2W-1:0] cfg_log2_q;
  logic [TileIdxW-1:0] cfg_tm1_q;
  logic                cfg_uni_q;
  logic [PicW-1:0]     cfg_min_q;

  // Tile position state
  logic [TileIdxW-1:0] tile_counter_q;
  logic [SumW-1:0]     sum_q;
  logic [CtbsW-1:0]    prev_q;

  // Per-tile working registers
  logic                last_q;
  logic                uni_q;
  logic [ExplW-1:0]    expl_q;
  logic [CtbsW-1:0]    n_q;
  logic [CtbLog2W-1:0] l2_q;

  // Output register
  logic                m_valid_q;
  logic [LumaW-1:0]    out_luma_q;
  logic [TileIdxW-1:0] out_idx_q;
  logic                out_below_q;
  logic                out_neg_q;
  logic                out_last_q;

  // Accept-time values
  logic                accept;
  logic [CtbLog2W-1:0] l2_d;
  logic [PicW:0]       round_mask;
  logic [CtbsW-1:0]    n_d;
  logic [TileIdxW-1:0] tm1_d;
  logic                last_d;
  logic                div_start;
  logic [DivNW-1:0]    dividend_d;
  logic [DivDW-1:0]    divisor_d;

  // Finish-time values
  logic                div_done;
  logic [DivNW-1:0]    quotient;
  logic [CtbsW-1:0]    bound_d;
  logic [CtbsW-1:0]    size_d;
  logic                neg_d;
  logic [SumW-1:0]     sum_d;
  logic [LumaW-1:0]    luma_d;
  logic                out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Picture size in CTBs, rounded up, and the tile this beat asks for.
  always_comb begin
    if (cfg_log2_q < htsd_pkg::CtbLog2Min) begin
      l2_d = htsd_pkg::CtbLog2Min;
    end else if (cfg_log2_q > htsd_pkg::CtbLog2Max) begin
      l2_d = htsd_pkg::CtbLog2Max;
    end else begin
      l2_d = cfg_log2_q;
    end
    round_mask = ((PicW+1)'(1) << l2_d) - (PicW+1)'(1);
    n_d        = CtbsW'(({1'b0, cfg_pic_q} + round_mask) >> l2_d);
    if (cfg_tm1_q > TileIdxW'(htsd_pkg::MaxTiles - 1)) begin
      tm1_d = TileIdxW'(htsd_pkg::MaxTiles - 1);
    end else begin
      tm1_d = cfg_tm1_q;
    end
    last_d     = (tile_counter_q >= tm1_d);
    div_start  = accept && cfg_uni_q && !last_d;
    dividend_d = DivNW'(DivNW'({1'b0, tile_counter_q} + (TileIdxW+1)'(1)) * DivNW'(n_d));
    divisor_d  = DivDW'({1'b0, tm1_d}) + DivDW'(1);
  end

  htsd_div #(
    .DividendW (DivNW),
    .DivisorW  (DivDW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend_d),
    .divisor_i  (divisor_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Tile size in CTBs, then in luma samples.
  always_comb begin
    bound_d = last_q ? n_q : CtbsW'(quotient);
    neg_d   = 1'b0;
    sum_d   = sum_q;
    if (uni_q) begin
      size_d = (bound_d >= prev_q) ? (bound_d - prev_q) : '0;
    end else if (!last_q) begin
      size_d = CtbsW'({1'b0, expl_q}) + CtbsW'(1);
      sum_d  = sum_q + SumW'(size_d);
    end else if (sum_q > SumW'(n_q)) begin
      neg_d  = 1'b1;
      size_d = '0;
    end else begin
      size_d = CtbsW'(SumW'(n_q) - sum_q);
    end
    luma_d = LumaW'(size_d) << l2_q;
  end

  // Control, configuration, tile position and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      cfg_pic_q      <= PicW'(1920);
      cfg_log2_q     <= CtbLog2W'(6);
      cfg_tm1_q      <= '0;
      cfg_uni_q      <= 1'b1;
      cfg_min_q      <= PicW'(256);
      tile_counter_q <= '0;
      sum_q          <= '0;
      prev_q         <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      // Register writes; indexes beyond the list are dropped.
      if (cfg_valid_i) begin
        case (htsd_pkg::cfg_idx_e'(cfg_index_i))
          htsd_pkg::CfgPicSizeLuma:     cfg_pic_q  <= cfg_data_i;
          htsd_pkg::CfgCtbLog2Size:     cfg_log2_q <= cfg_data_i[CtbLog2W-1:0];
          htsd_pkg::CfgTileCountMinus1: cfg_tm1_q  <= cfg_data_i[TileIdxW-1:0];
          htsd_pkg::CfgUniformSpacing:  cfg_uni_q  <= cfg_data_i[0];
          htsd_pkg::CfgMinTileSize:     cfg_min_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // The output beat is loaded at finish and dropped once it is taken.
      if (state_q == StFinish && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= div_start ? StDivide : StFinish;
          end
        end
        StDivide: begin
          if (div_done) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            state_q <= StIdle;
            if (last_q) begin
              tile_counter_q <= '0;
              sum_q          <= '0;
              prev_q         <= '0;
            end else begin
              tile_counter_q <= tile_counter_q + TileIdxW'(1);
              sum_q          <= sum_d;
              if (uni_q) begin
                prev_q <= bound_d;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_d;
      uni_q  <= cfg_uni_q;
      expl_q <= s_axis_tdata[ExplW-1:0];
      n_q    <= n_d;
      l2_q   <= l2_d;
    end
    if (state_q == StFinish && out_free) begin
      out_luma_q  <= luma_d;
      out_idx_q   <= tile_counter_q;
      out_below_q <= (luma_d < LumaW'(cfg_min_q));
      out_neg_q   <= neg_d;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, out_neg_q, out_below_q, out_idx_q, out_luma_q};
  assign m_axis_tlast  = out_last_q;

endmodule
